// ----- rtl/ohm_pkg.sv -----
`timescale 1ns / 1ps

package ohm_pkg;

    // table geometry
    localparam int CAPACITY   = 256;
    localparam int SLOT_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int TAG_BITS   = 8;
    localparam int MAX_BITS   = 9;

    // fnv-1a over the key bytes
    localparam int KEY_BYTES  = (KEY_BITS + 7) / 8;
    localparam int HCNT_BITS  = $clog2(KEY_BYTES + 1);
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [TAG_BITS-1:0] TAG_MAX  = {TAG_BITS{1'b1}};
    localparam logic [TAG_BITS-1:0] TAG_DEAD = '0;
    localparam logic [TAG_BITS-1:0] GEN_RST  = TAG_BITS'(1);
    localparam logic [MAX_BITS-1:0] MAX_ENTRIES_RST = MAX_BITS'(192);

    typedef enum logic [1:0] {
        MODE_GET = 2'd0,
        MODE_PUT = 2'd1,
        MODE_DEL = 2'd2,
        MODE_CLR = 2'd3
    } t_mode;

    // one table slot as held in memory
    typedef struct packed {
        logic [TAG_BITS-1:0]   tag;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_entry;

endpackage

// ----- rtl/ohm_ram.sv -----
`timescale 1ns / 1ps

module ohm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/open_addressing_hash_map_unit.sv -----
`timescale 1ns / 1ps
// Linear-probing hash map with generation tags, one operation at a time.
// Command channel: present i_mode/i_key/i_value with start; the beat is taken
// when start is high and busy is low. Modes: get, put, delete, clear all.
// Result channel: o_done pulses for one cycle with o_found, o_read_value,
// o_slot, o_rejected and o_live_count; the receiver cannot stall it.
// Config channel: i_cfg_valid/o_cfg_ready write max_entries (always ready).
// Operation: get, put and delete first hash the key (one fnv-1a byte round per
// cycle on a shared constant multiplier), then issue one probe read per cycle
// through the memory read port until a hit or a full walk of all 256 slots;
// then the finish state, and the result beat shows the cycle after. For a miss
// and a put of a new key, the next command can be taken in the cycle in which
// the result beat shows. A put that moves an existing key stays busy through
// an erase state to kill the old slot. Clear all skips hash and probe and goes
// straight to the finish state; when the generation tag would wrap, busy stays
// high through a sweep in which every tag is zeroed.
// Reset: synchronous, active low; afterwards busy is high while the sweep
// clears the tag memory, one slot per cycle.

module open_addressing_hash_map_unit
    import ohm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_mode,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [MAX_BITS-1:0]   i_cfg_data,
    output logic                  o_done,
    output logic                  o_found,
    output logic [VALUE_BITS-1:0] o_read_value,
    output logic [SLOT_BITS-1:0]  o_slot,
    output logic                  o_rejected,
    output logic [CNT_BITS-1:0]   o_live_count
);

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_FINISH,
        S_ERASE
    } t_state;

    t_state                r_state, n_state;
    t_mode                 r_mode, n_mode;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_val, n_val;
    logic [31:0]           r_hash, n_hash;
    logic [HCNT_BITS-1:0]  r_hcnt, n_hcnt;
    logic [SLOT_BITS-1:0]  r_iss_slot, n_iss_slot;
    logic [CNT_BITS-1:0]   r_iss_cnt, n_iss_cnt;
    logic                  r_chk_vld, n_chk_vld;
    logic [SLOT_BITS-1:0]  r_chk_slot, n_chk_slot;
    logic                  r_match_vld, n_match_vld;
    logic [SLOT_BITS-1:0]  r_match_slot, n_match_slot;
    logic [VALUE_BITS-1:0] r_match_val, n_match_val;
    logic                  r_open_vld, n_open_vld;
    logic [SLOT_BITS-1:0]  r_open_slot, n_open_slot;
    logic [TAG_BITS-1:0]   r_gen, n_gen;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic [MAX_BITS-1:0]   r_max, n_max;
    logic [SLOT_BITS-1:0]  r_sweep, n_sweep;
    logic                  r_done, n_done;
    logic                  r_found, n_found;
    logic [VALUE_BITS-1:0] r_rval, n_rval;
    logic [SLOT_BITS-1:0]  r_slot, n_slot;
    logic                  r_rej, n_rej;

    logic                  w_we;
    logic [SLOT_BITS-1:0]  w_waddr;
    t_entry                w_wdata;
    t_entry                w_rdata;
    logic [31:0]           w_hash_step;
    logic [7:0]            w_byte;
    logic                  w_hit;
    logic                  w_open;
    logic                  w_room;

    // slot memory: tag, key and value side by side
    ohm_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_iss_slot),
        .o_rdata (w_rdata)
    );

    // one fnv-1a byte round on the shared multiplier
    assign w_byte      = 8'(r_key >> {r_hcnt, 3'b000});
    assign w_hash_step = 32'((r_hash ^ {24'd0, w_byte}) * FNV_PRIME);

    // compare of the slot read back in this cycle
    assign w_hit  = r_chk_vld && (w_rdata.tag == r_gen) && (w_rdata.key == r_key);
    assign w_open = r_chk_vld && (w_rdata.tag != r_gen);
    assign w_room = (r_count < CNT_BITS'(r_max)) && (r_count < CNT_BITS'(CAPACITY));

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_key        = r_key;
        n_val        = r_val;
        n_hash       = r_hash;
        n_hcnt       = r_hcnt;
        n_iss_slot   = r_iss_slot;
        n_iss_cnt    = r_iss_cnt;
        n_chk_vld    = r_chk_vld;
        n_chk_slot   = r_chk_slot;
        n_match_vld  = r_match_vld;
        n_match_slot = r_match_slot;
        n_match_val  = r_match_val;
        n_open_vld   = r_open_vld;
        n_open_slot  = r_open_slot;
        n_gen        = r_gen;
        n_count      = r_count;
        n_max        = r_max;
        n_sweep      = r_sweep;
        n_done       = 1'b0;
        n_found      = r_found;
        n_rval       = r_rval;
        n_slot       = r_slot;
        n_rej        = r_rej;
        w_we         = 1'b0;
        w_waddr      = r_sweep;
        w_wdata      = '0;

        if (i_cfg_valid) begin
            n_max = i_cfg_data;
        end

        case (r_state)
            // zero every tag, one slot per cycle
            S_SWEEP: begin
                w_we    = 1'b1;
                w_waddr = r_sweep;
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == SLOT_BITS'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            // take a command beat
            S_IDLE: begin
                if (start) begin
                    n_mode = t_mode'(i_mode);
                    n_key  = i_key;
                    n_val  = i_value;
                    n_hash = FNV_BASIS;
                    n_hcnt = '0;
                    if (t_mode'(i_mode) == MODE_CLR) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            // hash the key, then start the probe at the home slot
            S_HASH: begin
                n_hash = w_hash_step;
                n_hcnt = r_hcnt + 1'b1;
                if (r_hcnt == HCNT_BITS'(KEY_BYTES - 1)) begin
                    n_iss_slot  = w_hash_step[SLOT_BITS-1:0];
                    n_iss_cnt   = '0;
                    n_chk_vld   = 1'b0;
                    n_match_vld = 1'b0;
                    n_open_vld  = 1'b0;
                    n_state     = S_PROBE;
                end
            end
            // issue one read and check the previous one each cycle
            S_PROBE: begin
                if (r_iss_cnt != CNT_BITS'(CAPACITY)) begin
                    n_iss_slot = r_iss_slot + 1'b1;
                    n_iss_cnt  = r_iss_cnt + 1'b1;
                    n_chk_vld  = 1'b1;
                    n_chk_slot = r_iss_slot;
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (w_open && !r_open_vld) begin
                    n_open_vld  = 1'b1;
                    n_open_slot = r_chk_slot;
                end
                if (w_hit) begin
                    n_match_vld  = 1'b1;
                    n_match_slot = r_chk_slot;
                    n_match_val  = w_rdata.value;
                    n_chk_vld    = 1'b0;
                    n_state      = S_FINISH;
                end else if (!r_chk_vld && r_iss_cnt == CNT_BITS'(CAPACITY)) begin
                    n_state = S_FINISH;
                end
            end
            // apply the operation and register the result beat
            S_FINISH: begin
                n_done  = 1'b1;
                n_found = 1'b0;
                n_rval  = '0;
                n_slot  = '0;
                n_rej   = 1'b0;
                n_state = S_IDLE;
                case (r_mode)
                    MODE_GET: begin
                        if (r_match_vld) begin
                            n_found = 1'b1;
                            n_rval  = r_match_val;
                            n_slot  = r_match_slot;
                        end
                    end
                    MODE_PUT: begin
                        w_wdata.tag   = r_gen;
                        w_wdata.key   = r_key;
                        w_wdata.value = r_val;
                        if (r_match_vld) begin
                            // replace: store at the first free slot ahead of the old one
                            n_found = 1'b1;
                            w_we    = 1'b1;
                            if (r_open_vld) begin
                                w_waddr = r_open_slot;
                                n_slot  = r_open_slot;
                                n_state = S_ERASE;
                            end else begin
                                w_waddr = r_match_slot;
                                n_slot  = r_match_slot;
                            end
                        end else if (w_room && r_open_vld) begin
                            w_we    = 1'b1;
                            w_waddr = r_open_slot;
                            n_slot  = r_open_slot;
                            n_count = r_count + 1'b1;
                        end else begin
                            n_rej = 1'b1;
                        end
                    end
                    MODE_DEL: begin
                        if (r_match_vld) begin
                            n_found     = 1'b1;
                            n_slot      = r_match_slot;
                            n_count     = r_count - 1'b1;
                            w_we        = 1'b1;
                            w_waddr     = r_match_slot;
                            w_wdata.tag = TAG_DEAD;
                        end
                    end
                    MODE_CLR: begin
                        n_count = '0;
                        if (r_gen >= TAG_MAX) begin
                            n_gen   = GEN_RST;
                            n_sweep = '0;
                            n_state = S_SWEEP;
                        end else begin
                            n_gen = r_gen + 1'b1;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            // kill the old copy of a moved key
            S_ERASE: begin
                w_we        = 1'b1;
                w_waddr     = r_match_slot;
                w_wdata.tag = TAG_DEAD;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep     <= '0;
            r_gen       <= GEN_RST;
            r_count     <= '0;
            r_max       <= MAX_ENTRIES_RST;
            r_done      <= 1'b0;
            r_chk_vld   <= 1'b0;
            r_match_vld <= 1'b0;
            r_open_vld  <= 1'b0;
            r_mode      <= MODE_GET;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_gen       <= n_gen;
            r_count     <= n_count;
            r_max       <= n_max;
            r_done      <= n_done;
            r_chk_vld   <= n_chk_vld;
            r_match_vld <= n_match_vld;
            r_open_vld  <= n_open_vld;
            r_mode      <= n_mode;
        end
        r_key        <= n_key;
        r_val        <= n_val;
        r_hash       <= n_hash;
        r_hcnt       <= n_hcnt;
        r_iss_slot   <= n_iss_slot;
        r_iss_cnt    <= n_iss_cnt;
        r_chk_slot   <= n_chk_slot;
        r_match_slot <= n_match_slot;
        r_match_val  <= n_match_val;
        r_open_slot  <= n_open_slot;
        r_found      <= n_found;
        r_rval       <= n_rval;
        r_slot       <= n_slot;
        r_rej        <= n_rej;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_done       = r_done;
    assign o_found      = r_found;
    assign o_read_value = r_rval;
    assign o_slot       = r_slot;
    assign o_rejected   = r_rej;
    assign o_live_count = r_count;

    // a result beat only follows the finish cycle
    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_FINISH))
        else $error("result beat without a finish cycle");

    // live count stays within the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY))
        else $error("live count beyond capacity");

    // only a put can be refused
    a_rej_put_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_rej) |-> (r_mode == MODE_PUT))
        else $error("rejection on an operation other than put");

    // the generation tag never matches a dead slot
    a_gen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gen != TAG_DEAD)
        else $error("generation tag is zero");

    // memory writes happen only in the sweep, finish and erase cycles
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_SWEEP || r_state == S_FINISH || r_state == S_ERASE))
        else $error("slot write outside a write cycle");

endmodule

// ----- sim/tb_open_addressing_hash_map_unit.sv -----
`timescale 1ns / 1ps

module tb_open_addressing_hash_map_unit;
    import ohm_pkg::*;

    // one command or one limit write waiting for the driver
    typedef struct {
        bit                    is_cfg;
        t_mode                 mode;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [MAX_BITS-1:0]   limit;
        bit                    calm;
    } t_beat;

    // what one command should answer
    typedef struct {
        logic                  found;
        logic [VALUE_BITS-1:0] read_value;
        logic [SLOT_BITS-1:0]  slot;
        logic                  rejected;
        logic [CNT_BITS-1:0]   live_count;
    } t_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [1:0]            i_mode = MODE_GET;
    logic [KEY_BITS-1:0]   i_key = '0;
    logic [VALUE_BITS-1:0] i_value = '0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [MAX_BITS-1:0]   i_cfg_data = '0;
    logic                  o_done;
    logic                  o_found;
    logic [VALUE_BITS-1:0] o_read_value;
    logic [SLOT_BITS-1:0]  o_slot;
    logic                  o_rejected;
    logic [CNT_BITS-1:0]   o_live_count;

    t_beat    pending_beats[$];
    t_outcome outcomes_due[$];
    int       mismatch_count = 0;
    int       cmds_queued = 0;
    int       clears_queued = 0;
    bit       calm_phase = 1'b0;

    // driver bookkeeping
    bit cmd_beat = 1'b0;
    bit cfg_beat = 1'b0;
    bit cur_calm = 1'b0;
    bit gap_waits_idle = 1'b0;
    int idle_left = 0;

    // shadow copy of the table
    logic [KEY_BITS-1:0]   shadow_key   [CAPACITY] = '{default: '0};
    logic [VALUE_BITS-1:0] shadow_value [CAPACITY] = '{default: '0};
    logic [TAG_BITS-1:0]   shadow_tag   [CAPACITY] = '{default: '0};
    logic [TAG_BITS-1:0]   shadow_gen = GEN_RST;
    int                    shadow_live = 0;
    logic [MAX_BITS-1:0]   shadow_limit = MAX_ENTRIES_RST;

    open_addressing_hash_map_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_key        (i_key),
        .i_value      (i_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_found      (o_found),
        .o_read_value (o_read_value),
        .o_slot       (o_slot),
        .o_rejected   (o_rejected),
        .o_live_count (o_live_count)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // fnv-1a over the key bytes, low byte first
    function automatic logic [SLOT_BITS-1:0] home_of(logic [KEY_BITS-1:0] key);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < KEY_BYTES; i++) begin
            h = (h ^ 32'(key[8*i +: 8])) * FNV_PRIME;
        end
        return SLOT_BITS'(h % CAPACITY);
    endfunction

    // slot holding the live copy of a key, or -1
    function automatic int live_slot_of(logic [KEY_BITS-1:0] key);
        logic [SLOT_BITS-1:0] s;
        s = home_of(key);
        for (int n = 0; n < CAPACITY; n++) begin
            if (shadow_tag[s] == shadow_gen && shadow_key[s] == key) begin
                return int'(s);
            end
            s = SLOT_BITS'((s + 1) % CAPACITY);
        end
        return -1;
    endfunction

    // first slot from home that is not live, or -1
    function automatic int free_slot_of(logic [KEY_BITS-1:0] key);
        logic [SLOT_BITS-1:0] s;
        s = home_of(key);
        for (int n = 0; n < CAPACITY; n++) begin
            if (shadow_tag[s] != shadow_gen) begin
                return int'(s);
            end
            s = SLOT_BITS'((s + 1) % CAPACITY);
        end
        return -1;
    endfunction

    // run one command on the shadow table and return its answer
    function automatic t_outcome apply_command(t_mode mode, logic [KEY_BITS-1:0] key,
                                               logic [VALUE_BITS-1:0] value);
        t_outcome r;
        int       pos;
        r = '{default: '0};
        case (mode)
            MODE_GET: begin
                pos = live_slot_of(key);
                if (pos >= 0) begin
                    r.found = 1'b1;
                    r.read_value = shadow_value[pos];
                    r.slot = SLOT_BITS'(pos);
                end
            end
            MODE_PUT: begin
                pos = live_slot_of(key);
                // an existing key is dropped first and stored again
                if (pos >= 0) begin
                    r.found = 1'b1;
                    shadow_tag[pos] = TAG_DEAD;
                    shadow_live--;
                end
                if (pos < 0 && (shadow_live >= shadow_limit || shadow_live >= CAPACITY)) begin
                    r.rejected = 1'b1;
                end else begin
                    pos = free_slot_of(key);
                    if (pos >= 0) begin
                        shadow_key[pos] = key;
                        shadow_value[pos] = value;
                        shadow_tag[pos] = shadow_gen;
                        shadow_live++;
                        r.slot = SLOT_BITS'(pos);
                    end else begin
                        r.rejected = 1'b1;
                    end
                end
            end
            MODE_DEL: begin
                pos = live_slot_of(key);
                if (pos >= 0) begin
                    r.found = 1'b1;
                    r.slot = SLOT_BITS'(pos);
                    shadow_tag[pos] = TAG_DEAD;
                    shadow_live--;
                end
            end
            default: begin
                // clear all: new generation, wipe tags when it would wrap
                if (shadow_gen >= TAG_MAX) begin
                    foreach (shadow_tag[i]) shadow_tag[i] = TAG_DEAD;
                    shadow_gen = GEN_RST;
                end else begin
                    shadow_gen = shadow_gen + 1'b1;
                end
                shadow_live = 0;
            end
        endcase
        r.live_count = CNT_BITS'(shadow_live);
        return r;
    endfunction

    task automatic note_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        // keep the log bounded when the block is badly off
        if (mismatch_count <= 200) begin
            $display("%0t ns: %s is %0h, expected %0h", $time, field, got, want);
        end
    endtask

    function automatic void push_cmd(t_mode mode, logic [KEY_BITS-1:0] key,
                                     logic [VALUE_BITS-1:0] value);
        t_beat b;
        b.is_cfg = 1'b0;
        b.mode = mode;
        b.key = key;
        b.value = value;
        b.limit = '0;
        b.calm = calm_phase;
        pending_beats.push_back(b);
        cmds_queued++;
        if (mode == MODE_CLR) clears_queued++;
    endfunction

    function automatic void push_cfg(logic [MAX_BITS-1:0] limit);
        t_beat b;
        b.is_cfg = 1'b1;
        b.mode = MODE_GET;
        b.key = '0;
        b.value = '0;
        b.limit = limit;
        b.calm = calm_phase;
        pending_beats.push_back(b);
    endfunction

    function automatic logic [VALUE_BITS-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    // random key that hashes to the given home slot
    function automatic logic [KEY_BITS-1:0] key_at_home(logic [SLOT_BITS-1:0] target);
        logic [KEY_BITS-1:0] k;
        do k = KEY_BITS'($urandom); while (home_of(k) != target);
        return k;
    endfunction

    // driver: presents one beat at a time, changes inputs at the falling edge
    always @(negedge i_clk) begin
        t_beat head;
        logic  hold_cmd;
        logic  hold_cfg;
        logic  next_start;
        logic  next_cfg;
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
        end else begin
            hold_cmd = start && !cmd_beat;
            hold_cfg = i_cfg_valid && !cfg_beat;
            next_start = hold_cmd;
            next_cfg = hold_cfg;
            if (!hold_cmd && !hold_cfg) begin
                // a beat just went through: maybe pause for a burst
                if ((start || i_cfg_valid) && !cur_calm && $urandom_range(0, 2) == 0) begin
                    idle_left = $urandom_range(1, 17);
                    gap_waits_idle = $urandom_range(0, 1);
                end
                if (idle_left > 0) begin
                    if (!gap_waits_idle || !busy) idle_left--;
                end else if (pending_beats.size() != 0) begin
                    head = pending_beats[0];
                    if (!head.is_cfg) begin
                        head = pending_beats.pop_front();
                        next_start = 1'b1;
                        i_mode <= head.mode;
                        i_key <= head.key;
                        i_value <= head.value;
                        cur_calm = head.calm;
                    end else if (outcomes_due.size() == 0 && !busy) begin
                        // limit writes only into an idle block
                        head = pending_beats.pop_front();
                        next_cfg = 1'b1;
                        i_cfg_data <= head.limit;
                        cur_calm = head.calm;
                    end
                end
            end
            start <= next_start;
            i_cfg_valid <= next_cfg;
        end
    end

    // monitor: checks results, predicts accepted commands, tracks the limit
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            cmd_beat <= 1'b0;
            cfg_beat <= 1'b0;
        end else begin
            if (o_done) begin
                if (outcomes_due.size() == 0) begin
                    note_mismatch("result with no command pending", 32'd1, 32'd0);
                end else begin
                    want = outcomes_due.pop_front();
                    if (o_found !== want.found)
                        note_mismatch("found", o_found, want.found);
                    if (o_read_value !== want.read_value)
                        note_mismatch("read_value", o_read_value, want.read_value);
                    if (o_slot !== want.slot)
                        note_mismatch("slot", o_slot, want.slot);
                    if (o_rejected !== want.rejected)
                        note_mismatch("rejected", o_rejected, want.rejected);
                    if (o_live_count !== want.live_count)
                        note_mismatch("live_count", o_live_count, want.live_count);
                end
            end
            if (start && !busy) begin
                outcomes_due.push_back(apply_command(t_mode'(i_mode), i_key, i_value));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                shadow_limit = i_cfg_data;
            end
            cmd_beat <= start && !busy;
            cfg_beat <= i_cfg_valid && o_cfg_ready;
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [KEY_BITS-1:0]  ka, kb, kc, kd, k;
        logic [KEY_BITS-1:0]  pool [12];
        logic [KEY_BITS-1:0]  fill_keys [CAPACITY];
        logic [SLOT_BITS-1:0] anchor;
        logic [MAX_BITS-1:0]  limit;
        int                   pool_n;
        int                   pick;
        bit                   fill_done;

        fill_done = 1'b0;
        ka = key_at_home(SLOT_BITS'(CAPACITY - 1));
        kb = key_at_home(SLOT_BITS'(CAPACITY - 1));
        kc = key_at_home(SLOT_BITS'(CAPACITY - 1));
        kd = KEY_BITS'($urandom);

        // directed: extremes, replace, collisions with wrap, clear, limits
        push_cmd(MODE_GET, '0, rand_value());
        push_cmd(MODE_DEL, '1, '0);
        push_cmd(MODE_PUT, '0, '1);
        push_cmd(MODE_PUT, '1, '0);
        push_cmd(MODE_GET, '0, '0);
        push_cmd(MODE_GET, '1, '1);
        push_cmd(MODE_PUT, '0, 32'h5a5a_0f0f);
        push_cmd(MODE_GET, '0, '0);
        push_cmd(MODE_PUT, ka, rand_value());
        push_cmd(MODE_PUT, kb, rand_value());
        push_cmd(MODE_PUT, kc, rand_value());
        push_cmd(MODE_DEL, ka, '0);
        // probe steps over the hole, then the key moves back into it
        push_cmd(MODE_GET, kc, '0);
        push_cmd(MODE_PUT, kc, rand_value());
        push_cmd(MODE_GET, kc, '0);
        push_cmd(MODE_CLR, '0, '0);
        push_cmd(MODE_GET, '1, '0);
        push_cmd(MODE_PUT, kb, rand_value());
        // zero limit: new keys refused, replacing an existing key still works
        push_cfg('0);
        push_cmd(MODE_PUT, kd, rand_value());
        push_cmd(MODE_PUT, kb, rand_value());
        push_cfg(MAX_BITS'(1));
        push_cmd(MODE_PUT, ka, rand_value());
        push_cmd(MODE_DEL, kb, '0);
        push_cmd(MODE_PUT, ka, rand_value());
        push_cmd(MODE_CLR, '0, '0);
        push_cfg(MAX_ENTRIES_RST);

        // random episodes over small key pools
        while (cmds_queued < 1825) begin
            calm_phase = (cmds_queued >= 1580);

            // fill the whole table once, with the limit above capacity
            if (!fill_done && cmds_queued >= 1100) begin
                fill_done = 1'b1;
                push_cfg('1);
                push_cmd(MODE_CLR, '0, '0);
                for (int i = 0; i < CAPACITY; i++) begin
                    fill_keys[i] = (i < 8) ? key_at_home(SLOT_BITS'(CAPACITY - 1))
                                           : KEY_BITS'($urandom);
                    push_cmd(MODE_PUT, fill_keys[i], rand_value());
                end
                repeat (3) push_cmd(MODE_PUT, KEY_BITS'($urandom), rand_value());
                push_cmd(MODE_PUT, fill_keys[$urandom_range(0, CAPACITY - 1)], rand_value());
                repeat (8) push_cmd(MODE_GET, fill_keys[$urandom_range(0, CAPACITY - 1)], '0);
                repeat (4) push_cmd(MODE_DEL, fill_keys[$urandom_range(0, CAPACITY - 1)], '0);
                repeat (4) push_cmd(MODE_PUT, KEY_BITS'($urandom), rand_value());
                push_cmd(MODE_CLR, '0, '0);
            end

            // bring the generation near its wrap so later clears roll it over
            if (clears_queued < 250 && cmds_queued >= 800) begin
                repeat (250 - clears_queued) push_cmd(MODE_CLR, $urandom, $urandom);
            end

            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 7))
                    0:       limit = '0;
                    1:       limit = MAX_BITS'(1);
                    2:       limit = MAX_BITS'($urandom_range(2, 16));
                    3:       limit = MAX_ENTRIES_RST;
                    4:       limit = MAX_BITS'(CAPACITY - 1);
                    5:       limit = MAX_BITS'(CAPACITY);
                    6:       limit = '1;
                    default: limit = MAX_BITS'($urandom_range(0, 511));
                endcase
                push_cfg(limit);
            end

            // pool with shared home slots, often at the top so probing wraps
            case ($urandom_range(0, 3))
                0:       anchor = SLOT_BITS'(CAPACITY - 1);
                1:       anchor = SLOT_BITS'(CAPACITY - 2);
                default: anchor = SLOT_BITS'($urandom);
            endcase
            pool_n = $urandom_range(1, 12);
            for (int i = 0; i < pool_n; i++) begin
                case ($urandom_range(0, 7))
                    0:       pool[i] = '0;
                    1:       pool[i] = '1;
                    2, 3:    pool[i] = KEY_BITS'($urandom);
                    default: pool[i] = key_at_home(anchor + SLOT_BITS'($urandom_range(0, 2)));
                endcase
            end

            repeat ($urandom_range(1, 24)) begin
                pick = $urandom_range(0, 99);
                // now and then a key from outside the pool
                k = ($urandom_range(0, 9) == 0) ? KEY_BITS'($urandom)
                                                : pool[$urandom_range(0, pool_n - 1)];
                if (pick < 35)      push_cmd(MODE_GET, k, rand_value());
                else if (pick < 72) push_cmd(MODE_PUT, k, rand_value());
                else if (pick < 90) push_cmd(MODE_DEL, k, rand_value());
                else                push_cmd(MODE_CLR, k, rand_value());
            end
            repeat ($urandom_range(0, 2)) push_cmd(MODE_CLR, $urandom, $urandom);
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain, then watch a while for stray results
        while (pending_beats.size() != 0 || start || i_cfg_valid || outcomes_due.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // hang guard
    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- open_addressing_hash_map_unit.f -----
rtl/ohm_pkg.sv
rtl/ohm_ram.sv
rtl/open_addressing_hash_map_unit.sv
sim/tb_open_addressing_hash_map_unit.sv
